// ===== hdl/ucs_pkg.sv =====
package ucs_pkg;

	localparam int unsigned SETUP_BYTES = 8;
	localparam logic [15:0] BUFFER_SIZE_RESET = 16'd4096;

	// event codes
	localparam logic [1:0] EV_START    = 2'd0;
	localparam logic [1:0] EV_RESET    = 2'd1;
	localparam logic [1:0] EV_NOT_RDY  = 2'd2;
	localparam logic [1:0] EV_COMPLETE = 2'd3;

	localparam logic [1:0] STAGE_SETUP  = 2'd0;
	localparam logic [1:0] STAGE_DATA   = 2'd1;
	localparam logic [1:0] STAGE_STATUS = 2'd2;

	localparam logic EP_OUT = 1'b0;
	localparam logic EP_IN  = 1'b1;

	localparam logic [1:0] END_NONE = 2'd0;
	localparam logic [1:0] END_OUT  = 2'd1;
	localparam logic [1:0] END_IN   = 2'd2;

	localparam logic [2:0] START_NONE      = 3'd0;
	localparam logic [2:0] START_SETUP     = 3'd1;
	localparam logic [2:0] START_CTRL_DATA = 3'd2;
	localparam logic [2:0] START_STATUS2   = 3'd3;
	localparam logic [2:0] START_STATUS3   = 3'd4;

	localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
	localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
	localparam logic [7:0] REQ_SET_INTERFACE = 8'd11;
	localparam logic [7:0] DIR_IN_MASK       = 8'h80;
	localparam logic [7:0] RT_OUT_STD_DEVICE    = 8'h00;
	localparam logic [7:0] RT_OUT_STD_INTERFACE = 8'h01;

	// phase codes as reported on the result
	localparam logic [2:0] PHC_NONE     = 3'd0;
	localparam logic [2:0] PHC_SETUP    = 3'd1;
	localparam logic [2:0] PHC_DATA_OUT = 3'd2;
	localparam logic [2:0] PHC_DATA_IN  = 3'd3;
	localparam logic [2:0] PHC_NRDY_OUT = 3'd4;
	localparam logic [2:0] PHC_NRDY_IN  = 3'd5;
	localparam logic [2:0] PHC_STATUS   = 3'd6;

	typedef enum logic [6:0] {
		PH_NONE     = 7'b0000001,
		PH_SETUP    = 7'b0000010,
		PH_DATA_OUT = 7'b0000100,
		PH_DATA_IN  = 7'b0001000,
		PH_NRDY_OUT = 7'b0010000,
		PH_NRDY_IN  = 7'b0100000,
		PH_STATUS   = 7'b1000000
	} phase_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_SETUP:    code = PHC_SETUP;
			PH_DATA_OUT: code = PHC_DATA_OUT;
			PH_DATA_IN:  code = PHC_DATA_IN;
			PH_NRDY_OUT: code = PHC_NRDY_OUT;
			PH_NRDY_IN:  code = PHC_NRDY_IN;
			PH_STATUS:   code = PHC_STATUS;
			default:     code = PHC_NONE;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/usb_control_endpoint_sequencer_top.sv =====
// Endpoint-0 control transfer sequencer. Each accepted event (start, reset,
// not-ready, complete) yields exactly one command result. An event is taken
// into an input register, decoded against the current control phase and the
// commands land in an output register, from which the result is presented.
// While the output register is empty or being taken, a new event can be
// accepted every cycle; the rate is one event per clock, set by the phase
// register that each event reads and updates. The output register
// holds a result until it is taken while the next event waits in the input
// register. buffer_size is written through cfg_wr_en/cfg_wr_data and must
// only change while no event is in flight.
module usb_control_endpoint_sequencer_top
	import ucs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        ep_in,
	input  logic [1:0]  stage,
	input  logic [7:0]  setup_request_type,
	input  logic [7:0]  setup_request,
	input  logic [15:0] setup_value,
	input  logic [15:0] setup_length,
	input  logic        handler_ok,
	input  logic [15:0] handler_actual,
	input  logic [15:0] trb_remaining,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        stall_out,
	output logic [1:0]  end_transfer,
	output logic [2:0]  start_kind,
	output logic        start_ep_in,
	output logic [15:0] start_length,
	output logic        address_valid,
	output logic [6:0]  address_value,
	output logic        reset_config,
	output logic        start_endpoints,
	output logic        configured,
	output logic [2:0]  phase,
	output logic [15:0] received_length
);

	typedef struct packed {
		logic        stall;
		logic [1:0]  endx;
		logic [2:0]  kind;
		logic        kep;
		logic [15:0] klen;
		logic        av;
		logic [6:0]  aval;
		logic        rcfg;
		logic        seps;
		logic        cfg;
		logic [2:0]  ph;
		logic [15:0] rxlen;
	} result_t;

	logic [15:0] buffer_size_q;

	// control state
	phase_t      phase_q;
	logic [7:0]  saved_rt_q;
	logic [7:0]  saved_req_q;
	logic [15:0] saved_value_q;
	logic [15:0] saved_length_q;
	logic        configured_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic        ep_in_s1;
	logic [1:0]  stage_s1;
	logic [7:0]  setup_rt_s1;
	logic [7:0]  setup_req_s1;
	logic [15:0] setup_value_s1;
	logic [15:0] setup_length_s1;
	logic        handler_ok_s1;
	logic [15:0] handler_actual_s1;
	logic [15:0] trb_remaining_s1;

	// output stage
	logic        valid_s2;
	result_t     res_s2;

	logic advance;
	logic fire;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// saved setup packet as seen by this event
	logic        take_setup;
	logic [7:0]  cur_rt;
	logic [7:0]  cur_req;
	logic [15:0] cur_value;
	logic [15:0] cur_length;

	assign take_setup = (req_type_s1 == EV_COMPLETE) && (phase_q == PH_SETUP);
	assign cur_rt     = take_setup ? setup_rt_s1     : saved_rt_q;
	assign cur_req    = take_setup ? setup_req_s1    : saved_req_q;
	assign cur_value  = take_setup ? setup_value_s1  : saved_value_q;
	assign cur_length = take_setup ? setup_length_s1 : saved_length_q;

	// standard request decode
	logic dec_ok;
	logic dec_av;
	logic dec_rcfg;
	logic dec_seps;

	always_comb begin
		dec_ok   = handler_ok_s1;
		dec_av   = 1'b0;
		dec_rcfg = 1'b0;
		dec_seps = 1'b0;
		if (cur_rt == RT_OUT_STD_DEVICE) begin
			if (cur_req == REQ_SET_ADDRESS) begin
				dec_av = 1'b1;
				dec_ok = 1'b1;
			end else if (cur_req == REQ_SET_CONFIG) begin
				dec_rcfg = 1'b1;
				dec_seps = handler_ok_s1 && (cur_value != 16'd0);
			end
		end else if (cur_rt == RT_OUT_STD_INTERFACE && cur_req == REQ_SET_INTERFACE) begin
			dec_rcfg = 1'b1;
			dec_seps = handler_ok_s1;
		end
	end

	logic [15:0] reply_len;
	logic [15:0] rx_len;

	assign reply_len = (handler_actual_s1 > buffer_size_q) ? buffer_size_q : handler_actual_s1;
	assign rx_len    = (trb_remaining_s1 > buffer_size_q) ? 16'd0
	                                                      : buffer_size_q - trb_remaining_s1;

	result_t res;
	phase_t  phase_d;
	logic    cfg_d;

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		cfg_d   = configured_q;
		case (req_type_s1)
			EV_START: begin
				res.kind = START_SETUP;
				res.klen = 16'(SETUP_BYTES);
				phase_d  = PH_SETUP;
			end
			EV_RESET: begin
				res.endx = END_OUT;
				phase_d  = PH_NONE;
			end
			EV_NOT_RDY: begin
				case (phase_q)
					PH_SETUP: begin
						if (stage_s1 inside {STAGE_DATA, STAGE_STATUS}) begin
							res.stall = 1'b1;
							res.kind  = START_SETUP;
							res.klen  = 16'(SETUP_BYTES);
							phase_d   = PH_SETUP;
						end
					end
					PH_DATA_OUT, PH_DATA_IN: begin
						// opposite-direction data token aborts the transfer
						if (stage_s1 == STAGE_DATA &&
						    ep_in_s1 == (phase_q == PH_DATA_OUT)) begin
							res.endx  = (phase_q == PH_DATA_OUT) ? END_OUT : END_IN;
							res.stall = 1'b1;
							res.kind  = START_SETUP;
							res.klen  = 16'(SETUP_BYTES);
							phase_d   = PH_SETUP;
						end
					end
					PH_NRDY_OUT, PH_NRDY_IN: begin
						if (ep_in_s1 == (phase_q == PH_NRDY_IN)) begin
							res.kind = (saved_length_q != 16'd0) ? START_STATUS3
							                                     : START_STATUS2;
							res.kep  = ep_in_s1;
							phase_d  = PH_STATUS;
						end
					end
					default: ;
				endcase
			end
			default: begin
				case (phase_q)
					PH_SETUP: begin
						if (cur_length != 16'd0 && (cur_rt & DIR_IN_MASK) == 8'h00) begin
							res.kind = START_CTRL_DATA;
							res.kep  = EP_OUT;
							res.klen = buffer_size_q;
							phase_d  = PH_DATA_OUT;
						end else begin
							res.av   = dec_av;
							res.aval = dec_av ? cur_value[6:0] : 7'd0;
							res.rcfg = dec_rcfg;
							res.seps = dec_seps;
							if (dec_rcfg) cfg_d = dec_seps;
							if (!dec_ok) begin
								res.stall = 1'b1;
								res.kind  = START_SETUP;
								res.klen  = 16'(SETUP_BYTES);
								phase_d   = PH_SETUP;
							end else if (cur_length != 16'd0) begin
								res.kind = START_CTRL_DATA;
								res.kep  = EP_IN;
								res.klen = reply_len;
								phase_d  = PH_DATA_IN;
							end else begin
								phase_d = PH_NRDY_IN;
							end
						end
					end
					PH_DATA_OUT: begin
						res.rxlen = rx_len;
						res.av    = dec_av;
						res.aval  = dec_av ? cur_value[6:0] : 7'd0;
						res.rcfg  = dec_rcfg;
						res.seps  = dec_seps;
						if (dec_rcfg) cfg_d = dec_seps;
						if (!dec_ok) begin
							res.stall = 1'b1;
							res.kind  = START_SETUP;
							res.klen  = 16'(SETUP_BYTES);
							phase_d   = PH_SETUP;
						end else begin
							phase_d = PH_NRDY_IN;
						end
					end
					PH_DATA_IN: phase_d = PH_NRDY_OUT;
					PH_STATUS: begin
						res.kind = START_SETUP;
						res.klen = 16'(SETUP_BYTES);
						phase_d  = PH_SETUP;
					end
					default: ;
				endcase
			end
		endcase
		res.cfg = cfg_d;
		res.ph  = phase_code(phase_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUFFER_SIZE_RESET;
		end else if (cfg_wr_en) begin
			buffer_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_NONE;
			saved_rt_q     <= 8'd0;
			saved_req_q    <= 8'd0;
			saved_value_q  <= 16'd0;
			saved_length_q <= 16'd0;
			configured_q   <= 1'b0;
		end else if (fire) begin
			phase_q        <= phase_d;
			configured_q   <= cfg_d;
			saved_rt_q     <= cur_rt;
			saved_req_q    <= cur_req;
			saved_value_q  <= cur_value;
			saved_length_q <= cur_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance)  valid_s2 <= valid_s1;
		end
	end

	// capture the transaction when the input stage frees up
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1       <= req_type;
			ep_in_s1          <= ep_in;
			stage_s1          <= stage;
			setup_rt_s1       <= setup_request_type;
			setup_req_s1      <= setup_request;
			setup_value_s1    <= setup_value;
			setup_length_s1   <= setup_length;
			handler_ok_s1     <= handler_ok;
			handler_actual_s1 <= handler_actual;
			trb_remaining_s1  <= trb_remaining;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign stall_out       = res_s2.stall;
	assign end_transfer    = res_s2.endx;
	assign start_kind      = res_s2.kind;
	assign start_ep_in     = res_s2.kep;
	assign start_length    = res_s2.klen;
	assign address_valid   = res_s2.av;
	assign address_value   = res_s2.aval;
	assign reset_config    = res_s2.rcfg;
	assign start_endpoints = res_s2.seps;
	assign configured      = res_s2.cfg;
	assign phase           = res_s2.ph;
	assign received_length = res_s2.rxlen;

endmodule
